[rtl/core/nsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helper functions for the sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // Most commas counted; one more field is added at the verdict.
    localparam logic [7:0] COMMA_MAX = 8'd254;
    localparam logic [1:0] ADDR_FULL = 2'd3;
    localparam logic [1:0] HEX_DONE  = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } nsc_item_t;

    typedef struct packed {
        logic        checksum_ok;
        logic        checksum_present;
        logic        start_ok;
        logic [23:0] formatter;
        logic        formatter_valid;
        logic [7:0]  field_count;
    } nsc_result_t;

    // Upper-case ASCII letters only.
    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

    // Uppercase hex spelling of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'h30 + {4'd0, n};
        end else begin
            r = 8'h37 + {4'd0, n};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/nmea_sentence_checker_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core
// Checks received NMEA 0183 lines byte by byte and gives one verdict item
// per line: checksum, start character, address tail and field count.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                       | Item
//  --------+-----------------------------+-------------------------------------
//  input   | s_valid, s_ready, s_item    | one byte of a line, last flag
//  result  | m_valid, m_ready, m_result  | verdict, after the line's last byte
//
//  Each byte waits in the input register and updates the line state as it
//  leaves it; a new byte can be taken every cycle while no last byte waits.
//  The result register loads the verdict as the last byte leaves the input
//  register; that byte waits only while an unaccepted verdict is held.
//  A stall on the result side holds back only a last byte, and the bytes
//  behind it. aresetn (synchronous, active low) empties both registers and
//  clears the line state, so the next byte starts a line.
//
module nmea_sentence_checker_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire nsc_pkg::nsc_item_t   s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output nsc_pkg::nsc_result_t      m_result
);

    logic                 hold_valid;
    nsc_pkg::nsc_item_t   hold_item;
    logic                 out_free;
    logic                 consume;
    nsc_pkg::nsc_result_t verdict;

    // Advance the held byte unless it closes a line and the result register
    // is still occupied.
    assign consume = hold_valid && (!hold_item.last || out_free);

    nsc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .consume    (consume),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    // Update the line state and form the verdict from the byte being consumed.
    nsc_line_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .item    (hold_item),
        .verdict (verdict)
    );

    // Load a verdict only when the line's last byte is consumed.
    nsc_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (consume && hold_item.last),
        .load_result (verdict),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

endmodule
`default_nettype wire

[rtl/core/nsc_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_in_stage
// Input register: captures one byte item and holds it until it is consumed.
// ----------------------------------------------------------------------------
module nsc_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire nsc_pkg::nsc_item_t s_item,
    input  wire logic               consume,
    output logic                    hold_valid,
    output nsc_pkg::nsc_item_t      hold_item
);

    logic               in_valid_reg;
    nsc_pkg::nsc_item_t in_item_reg;

    // Free when empty, or when the held item leaves this cycle.
    assign s_ready    = !in_valid_reg || consume;
    assign hold_valid = in_valid_reg;
    assign hold_item  = in_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

[rtl/core/nsc_line_state.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_line_state
// Per-line accumulation (XOR, checksum characters, address, commas) and the
// verdict built from the state after the current byte.
// ----------------------------------------------------------------------------
module nsc_line_state (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire nsc_pkg::nsc_item_t item,
    output nsc_pkg::nsc_result_t    verdict
);

    logic        at_line_start_reg,    at_line_start_next;
    logic        start_valid_reg,      start_valid_next;
    logic        star_seen_reg,        star_seen_next;
    logic [1:0]  after_star_count_reg, after_star_count_next;
    logic [7:0]  xor_sum_reg,          xor_sum_next;
    logic [7:0]  hex_high_char_reg,    hex_high_char_next;
    logic [7:0]  hex_low_char_reg,     hex_low_char_next;
    logic        address_closed_reg,   address_closed_next;
    logic [1:0]  address_length_reg,   address_length_next;
    logic [23:0] address_tail_reg,     address_tail_next;
    logic [7:0]  comma_count_reg,      comma_count_next;

    logic [7:0] ch_up;
    logic       fvalid;

    assign ch_up = nsc_pkg::to_upper(item.ch);

    always_comb begin
        at_line_start_next    = 1'b0;
        start_valid_next      = start_valid_reg;
        star_seen_next        = star_seen_reg;
        after_star_count_next = after_star_count_reg;
        xor_sum_next          = xor_sum_reg;
        hex_high_char_next    = hex_high_char_reg;
        hex_low_char_next     = hex_low_char_reg;
        address_closed_next   = address_closed_reg;
        address_length_next   = address_length_reg;
        address_tail_next     = address_tail_reg;
        comma_count_next      = comma_count_reg;

        if (star_seen_reg) begin
            if (after_star_count_reg == 2'd0) begin
                hex_high_char_next    = ch_up;
                after_star_count_next = 2'd1;
            end else if (after_star_count_reg == 2'd1) begin
                hex_low_char_next     = ch_up;
                after_star_count_next = nsc_pkg::HEX_DONE;
            end
        end else if (item.ch == nsc_pkg::CH_STAR) begin
            star_seen_next = 1'b1;
        end else begin
            if (!at_line_start_reg) begin
                xor_sum_next = xor_sum_reg ^ item.ch;
            end
            if (item.ch == nsc_pkg::CH_COMMA && comma_count_reg < nsc_pkg::COMMA_MAX) begin
                comma_count_next = comma_count_reg + 8'd1;
            end
        end

        if (at_line_start_reg) begin
            start_valid_next = (item.ch == nsc_pkg::CH_DOLLAR) ||
                               (item.ch == nsc_pkg::CH_BANG);
        end else if (!address_closed_reg) begin
            if (item.ch == nsc_pkg::CH_COMMA) begin
                address_closed_next = 1'b1;
            end else begin
                address_tail_next = {address_tail_reg[15:0], ch_up};
                if (address_length_reg < nsc_pkg::ADDR_FULL) begin
                    address_length_next = address_length_reg + 2'd1;
                end
            end
        end
    end

    assign fvalid = start_valid_next && (address_length_next == nsc_pkg::ADDR_FULL);

    always_comb begin
        verdict.checksum_present = star_seen_next;
        verdict.start_ok         = start_valid_next;
        verdict.formatter_valid  = fvalid;
        verdict.formatter        = fvalid ? address_tail_next : 24'd0;
        verdict.field_count      = comma_count_next + 8'd1;
        if (!star_seen_next) begin
            verdict.checksum_ok = 1'b1;
        end else begin
            verdict.checksum_ok = start_valid_next &&
                (after_star_count_next == nsc_pkg::HEX_DONE) &&
                (hex_high_char_next == nsc_pkg::hex_char(xor_sum_next[7:4])) &&
                (hex_low_char_next  == nsc_pkg::hex_char(xor_sum_next[3:0]));
        end
    end

    // Clear everything on reset and once the final byte of a line is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last)) begin
            at_line_start_reg    <= 1'b1;
            start_valid_reg      <= 1'b0;
            star_seen_reg        <= 1'b0;
            after_star_count_reg <= 2'd0;
            xor_sum_reg          <= 8'd0;
            hex_high_char_reg    <= 8'd0;
            hex_low_char_reg     <= 8'd0;
            address_closed_reg   <= 1'b0;
            address_length_reg   <= 2'd0;
            address_tail_reg     <= 24'd0;
            comma_count_reg      <= 8'd0;
        end else if (step) begin
            at_line_start_reg    <= at_line_start_next;
            start_valid_reg      <= start_valid_next;
            star_seen_reg        <= star_seen_next;
            after_star_count_reg <= after_star_count_next;
            xor_sum_reg          <= xor_sum_next;
            hex_high_char_reg    <= hex_high_char_next;
            hex_low_char_reg     <= hex_low_char_next;
            address_closed_reg   <= address_closed_next;
            address_length_reg   <= address_length_next;
            address_tail_reg     <= address_tail_next;
            comma_count_reg      <= comma_count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/nsc_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_out_stage
// Result register: holds one verdict item until the consumer takes it.
// ----------------------------------------------------------------------------
module nsc_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire nsc_pkg::nsc_result_t load_result,
    output logic                      free,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output nsc_pkg::nsc_result_t      m_result
);

    logic                 out_valid_reg;
    nsc_pkg::nsc_result_t out_result_reg;

    assign free     = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_result_reg <= load_result;
        end
    end

endmodule
`default_nettype wire

[rtl/core/nsc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks on the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
module nsc_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire nsc_pkg::nsc_result_t m_result
);

    // Hold a stalled verdict item.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("stalled verdict changed");

    a_fmt_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.formatter_valid |-> m_result.start_ok)
        else $error("formatter valid without valid start");

    a_fmt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.formatter_valid |-> m_result.formatter == 24'd0)
        else $error("formatter not cleared");

    a_no_star: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.checksum_present |->
            m_result.checksum_ok && m_result.field_count != 8'd0)
        else $error("line without checksum failed or field count zero");

endmodule

bind nmea_sentence_checker_core nsc_checker u_nsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);
`default_nettype wire
